>>> sv/sle_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Serial line editor package
// Character codes and the result type shared by the editor modules.
// ----------------------------------------------------------------------------
package sle_pkg;

  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_BELL  = 8'h07;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_BS    = 8'h08;
  localparam logic [7:0] CH_DEL   = 8'h7F;
  localparam logic [7:0] CH_TILDE = 8'h7E;

  localparam int CAP_W = 10;
  localparam logic [CAP_W-1:0] CAP_RESET = 10'd512;

  typedef struct packed {
    logic [7:0] echo_byte;
    logic       store_valid;
    logic [7:0] store_byte;
    logic       line_done;
    logic       last;
  } result_t;

endpackage

>>> sv/serial_line_editor_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Serial line editor core
// Canonical terminal line editing: echo, erase, line end and buffer writes.
// A byte is held in the input register; its result words are registered at
// the output, one result word per cycle while out_ready is high. A byte leaves
// the input register with its last result (one to three), or with none.
// Reset clears the write position and sets the line capacity to 512.
// ----------------------------------------------------------------------------
module serial_line_editor_core #(
  parameter int LINE_DEPTH = 512
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          line_capacity_we,
  input  logic [sle_pkg::CAP_W-1:0]     line_capacity,
  input  logic                          rx_valid,
  output logic                          rx_ready,
  input  logic [7:0]                    rx_byte,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [7:0]                    echo_byte,
  output logic                          store_valid,
  output logic [$clog2(LINE_DEPTH)-1:0] store_addr,
  output logic [7:0]                    store_byte,
  output logic                          line_done,
  output logic                          last
);

  localparam int PW = $clog2(LINE_DEPTH);

  logic [sle_pkg::CAP_W-1:0] capacity;
  logic [PW-1:0]             write_position;
  logic                      item_valid;
  logic [7:0]                item_byte;
  logic [1:0]                step;

  sle_pkg::result_t dec_result;
  logic [PW-1:0]    dec_addr;
  logic [1:0]       dec_count;
  logic [PW-1:0]    dec_pos_next;

  logic out_free;
  logic step_fire;
  logic step_last;

  sle_decode #(
    .LINE_DEPTH(LINE_DEPTH)
  ) u_decode (
    .rx_byte    (item_byte),
    .pos        (write_position),
    .capacity   (capacity),
    .step       (step),
    .result     (dec_result),
    .result_addr(dec_addr),
    .count      (dec_count),
    .pos_next   (dec_pos_next)
  );

  assign out_free  = !out_valid || out_ready;
  assign step_last = (dec_count == 2'd0) || dec_result.last;
  assign step_fire = item_valid && ((dec_count == 2'd0) || out_free);
  assign rx_ready  = !item_valid || (step_fire && step_last);

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity       <= sle_pkg::CAP_RESET;
      write_position <= '0;
      item_valid     <= 1'b0;
      step           <= 2'd0;
      out_valid      <= 1'b0;
    end else begin
      if (line_capacity_we) begin
        capacity <= line_capacity;
      end

      if (step_fire) begin
        if (step_last) begin
          write_position <= dec_pos_next;
          step           <= 2'd0;
        end else begin
          step <= step + 2'd1;
        end
      end

      if (rx_valid && rx_ready) begin
        item_valid <= 1'b1;
        item_byte  <= rx_byte;
      end else if (step_fire && step_last) begin
        item_valid <= 1'b0;
      end

      if (step_fire && (dec_count != 2'd0)) begin
        out_valid   <= 1'b1;
        echo_byte   <= dec_result.echo_byte;
        store_valid <= dec_result.store_valid;
        store_addr  <= dec_addr;
        store_byte  <= dec_result.store_byte;
        line_done   <= dec_result.line_done;
        last        <= dec_result.last;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  a_pos_range : assert property (@(posedge clk) disable iff (rst)
    write_position <= PW'(LINE_DEPTH - 2))
    else $error("write position beyond buffer");

  a_step_range : assert property (@(posedge clk) disable iff (rst)
    item_valid |-> (step != 2'd3))
    else $error("step index out of range");

  a_done_is_lf : assert property (@(posedge clk) disable iff (rst)
    (out_valid && line_done) |-> (store_valid && last &&
      (echo_byte == sle_pkg::CH_LF) && (store_byte == sle_pkg::CH_LF)))
    else $error("line end word malformed");

  a_inner_store_cr : assert property (@(posedge clk) disable iff (rst)
    (out_valid && !last && store_valid) |-> (store_byte == sle_pkg::CH_CR))
    else $error("unexpected store before last word");

endmodule

>>> sv/sle_decode.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Serial line editor word decoder
// Classifies one received byte and forms the result selected by the step
// index, together with its buffer address, the result count and the next write
// position.
module sle_decode #(
  parameter int LINE_DEPTH = 512
) (
  input  logic [7:0]                    rx_byte,
  input  logic [$clog2(LINE_DEPTH)-1:0] pos,
  input  logic [sle_pkg::CAP_W-1:0]     capacity,
  input  logic [1:0]                    step,
  output sle_pkg::result_t              result,
  output logic [$clog2(LINE_DEPTH)-1:0] result_addr,
  output logic [1:0]                    count,
  output logic [$clog2(LINE_DEPTH)-1:0] pos_next
);

  localparam int PW = $clog2(LINE_DEPTH);
  localparam int BW = ((PW + 1) > sle_pkg::CAP_W) ? (PW + 1) : sle_pkg::CAP_W;
  localparam int CW = BW + 1;

  logic [7:0]    ch;
  logic          is_erase;
  logic          is_cr;
  logic          is_lf;
  logic          is_print;
  logic [CW-1:0] cap_eff;
  logic          fits;
  logic [PW:0]   pos_inc;
  logic [PW-1:0] addr_inc;

  always_comb begin
    ch       = (rx_byte == sle_pkg::CH_TAB) ? sle_pkg::CH_SPACE : rx_byte;
    is_erase = (ch == sle_pkg::CH_BS) || (ch == sle_pkg::CH_DEL);
    is_cr    = (ch == sle_pkg::CH_CR);
    is_lf    = (ch == sle_pkg::CH_LF);
    is_print = (ch >= sle_pkg::CH_SPACE) && (ch <= sle_pkg::CH_TILDE);

    cap_eff = CW'(capacity);
    if (cap_eff > CW'(LINE_DEPTH)) begin
      cap_eff = CW'(LINE_DEPTH);
    end
    fits = (CW'(pos) + CW'(2)) < cap_eff;

    pos_inc  = {1'b0, pos} + (PW + 1)'(1);
    addr_inc = (pos_inc > (PW + 1)'(LINE_DEPTH - 1)) ? PW'(LINE_DEPTH - 1)
                                                     : pos_inc[PW-1:0];
  end

  always_comb begin
    result      = '0;
    result_addr = '0;
    count       = 2'd0;
    pos_next    = pos;
    priority if (is_erase) begin
      if (pos != '0) begin
        count    = 2'd3;
        pos_next = pos - PW'(1);
      end
      result.echo_byte = (step == 2'd1) ? sle_pkg::CH_SPACE : sle_pkg::CH_BS;
    end else if (is_cr) begin
      count             = 2'd2;
      pos_next          = '0;
      result.store_valid = 1'b1;
      if (step == 2'd0) begin
        result.echo_byte  = sle_pkg::CH_CR;
        result.store_byte = sle_pkg::CH_CR;
        result_addr       = pos;
      end else begin
        result.echo_byte  = sle_pkg::CH_LF;
        result.store_byte = sle_pkg::CH_LF;
        result.line_done  = 1'b1;
        result_addr       = addr_inc;
      end
    end else if (is_lf) begin
      count              = 2'd1;
      pos_next           = '0;
      result.echo_byte   = sle_pkg::CH_LF;
      result.store_valid = 1'b1;
      result.store_byte  = sle_pkg::CH_LF;
      result.line_done   = 1'b1;
      result_addr        = pos;
    end else if (is_print) begin
      count = 2'd1;
      if (fits) begin
        pos_next           = pos_inc[PW-1:0];
        result.echo_byte   = ch;
        result.store_valid = 1'b1;
        result.store_byte  = ch;
        result_addr        = pos;
      end else begin
        result.echo_byte = sle_pkg::CH_BELL;
      end
    end else begin
      count = 2'd0;
    end
    result.last = (count == 2'd0) || (step == (count - 2'd1));
  end

endmodule
